FILE: rtl/core/infix_expression_evaluator_macros.svh
// Assertion macros shared by the evaluator RTL.
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define IEVAL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define IEVAL_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define IEVAL_ASSERT(lbl, prop, msg)
`define IEVAL_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/ieval_pkg.sv
// Types, codes and helpers for the infix expression evaluator.
`default_nettype none
package ieval_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_LPAR = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_DIV0 = 2'd1,
		STAT_BAD  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIG_RD,
		ST_DIG_WR,
		ST_LOOP_CHK,
		ST_LOOP_TOP,
		ST_RED_B,
		ST_RED_A,
		ST_RED_WAIT,
		ST_FIN_RD,
		ST_FIN_OUT
	} state_t;

	typedef enum logic [1:0] {
		MODE_OP,
		MODE_RPAR,
		MODE_END
	} mode_t;

	typedef enum logic [1:0] {
		AL_IDLE,
		AL_DIV,
		AL_PMUL,
		AL_PSQR
	} alu_st_t;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic        div_zero;
		logic [31:0] result;
	} alu_rsp_t;

	function automatic logic [1:0] rank(op_t code);
		unique case (code) inside
			OP_POW:         return 2'd3;
			OP_MUL, OP_DIV: return 2'd2;
			OP_ADD, OP_SUB: return 2'd1;
			default:        return 2'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ieval_if.sv
// Valid/ready channel interfaces for expression characters and results.
`default_nettype none
interface ieval_item_if;
	logic               valid;
	logic               ready;
	logic [7:0]         symbol;
	logic signed [31:0] variable_value;
	logic               last_symbol;
	modport source(output valid, symbol, variable_value, last_symbol, input ready);
	modport sink(input valid, symbol, variable_value, last_symbol, output ready);
endinterface

interface ieval_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;
	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ieval_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ieval_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/ieval_alu.sv
// Shared iterative arithmetic unit: add, sub, mul, restoring divide, power.
`default_nettype none
module ieval_alu (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ieval_pkg::alu_req_t req,
	output      ieval_pkg::alu_rsp_t rsp
);
	import ieval_pkg::*;

	alu_st_t     st_q, st_n;
	logic        done_q, done_n;
	logic        dz_q, dz_n;
	logic [31:0] res_q, res_n;
	logic [31:0] acc_q, acc_n;
	logic [31:0] base_q, base_n;
	logic [31:0] e_q, e_n;
	logic [31:0] rem_q, rem_n;
	logic        neg_q, neg_n;
	logic [4:0]  cnt_q, cnt_n;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [32:0] rem_sh, diff;
	logic [31:0] quo_nx, rem_nx;
	logic [31:0] abs_a, abs_b;

	assign prod  = mul_a * mul_b;
	assign abs_a = req.a[31] ? 32'(0 - req.a) : req.a;
	assign abs_b = req.b[31] ? 32'(0 - req.b) : req.b;

	// One restoring divide step
	assign rem_sh = {rem_q, acc_q[31]};
	assign diff   = rem_sh - {1'b0, base_q};
	assign rem_nx = diff[32] ? rem_sh[31:0] : diff[31:0];
	assign quo_nx = {acc_q[30:0], ~diff[32]};

	always_comb begin
		unique case (st_q)
			AL_PMUL: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			AL_PSQR: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = req.a;
				mul_b = req.b;
			end
		endcase
	end

	always_comb begin
		st_n   = st_q;
		done_n = 1'b0;
		dz_n   = 1'b0;
		res_n  = res_q;
		acc_n  = acc_q;
		base_n = base_q;
		e_n    = e_q;
		rem_n  = rem_q;
		neg_n  = neg_q;
		cnt_n  = cnt_q;
		unique case (st_q)
			AL_IDLE: begin
				if (req.start) begin
					case (req.op)
						OP_ADD: begin
							res_n  = req.a + req.b;
							done_n = 1'b1;
						end
						OP_SUB: begin
							res_n  = req.a - req.b;
							done_n = 1'b1;
						end
						OP_MUL: begin
							res_n  = prod[31:0];
							done_n = 1'b1;
						end
						OP_DIV: begin
							if (req.b == '0) begin
								res_n  = '0;
								dz_n   = 1'b1;
								done_n = 1'b1;
							end else begin
								acc_n  = abs_a;
								base_n = abs_b;
								rem_n  = '0;
								neg_n  = req.a[31] ^ req.b[31];
								cnt_n  = 5'd31;
								st_n   = AL_DIV;
							end
						end
						OP_POW: begin
							if (req.b[31]) begin
								// truncated 1/x^n for a negative exponent
								done_n = 1'b1;
								if (req.a == 32'd1) begin
									res_n = 32'd1;
								end else if (req.a == '1) begin
									res_n = req.b[0] ? '1 : 32'd1;
								end else if (req.a == '0) begin
									res_n = '0;
									dz_n  = 1'b1;
								end else begin
									res_n = '0;
								end
							end else begin
								acc_n  = 32'd1;
								base_n = req.a;
								e_n    = req.b;
								st_n   = AL_PMUL;
							end
						end
						default: begin
							res_n  = '0;
							done_n = 1'b1;
						end
					endcase
				end
			end
			AL_DIV: begin
				acc_n = quo_nx;
				rem_n = rem_nx;
				cnt_n = cnt_q - 5'd1;
				if (cnt_q == '0) begin
					res_n  = neg_q ? 32'(0 - quo_nx) : quo_nx;
					done_n = 1'b1;
					st_n   = AL_IDLE;
				end
			end
			AL_PMUL: begin
				if (e_q == '0) begin
					res_n  = acc_q;
					done_n = 1'b1;
					st_n   = AL_IDLE;
				end else begin
					if (e_q[0]) begin
						acc_n = prod[31:0];
					end
					st_n = AL_PSQR;
				end
			end
			AL_PSQR: begin
				base_n = prod[31:0];
				e_n    = {1'b0, e_q[31:1]};
				st_n   = AL_PMUL;
			end
			default: st_n = AL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= AL_IDLE;
			done_q <= 1'b0;
			dz_q   <= 1'b0;
		end else begin
			st_q   <= st_n;
			done_q <= done_n;
			dz_q   <= dz_n;
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= res_n;
		acc_q  <= acc_n;
		base_q <= base_n;
		e_q    <= e_n;
		rem_q  <= rem_n;
		neg_q  <= neg_n;
		cnt_q  <= cnt_n;
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign rsp.result   = res_q;
endmodule
`default_nettype wire

FILE: rtl/core/infix_expression_evaluator.sv
// Top level of the two-stack infix expression evaluator.
//
// Takes one expression character per beat on item (digits, letters for
// variable_value, + - * / ^ and parentheses) and, on the beat that carries
// last_symbol, delivers one result beat with the 32-bit wrapping value and
// a status (0 ok, 1 division by zero, 2 malformed or stack overflow; value
// is 0 whenever status is not 0). Operands and operators live on two
// STACK_DEPTH-entry RAM stacks with registered reads; a small sequencer pops,
// reduces through one shared arithmetic unit and pushes back. item.ready is
// high only while the sequencer is idle, so one character is worked at a
// time. A digit extending a number reads back and rewrites the top operand. Each
// reduction that an operator, ')' or the final character triggers pops an operator,
// reads operands b and a, and pushes the result once the arithmetic unit is done;
// / runs a restoring divide and ^ runs a multiply and a square per exponent bit. The last
// character also reads out the result; a result not yet taken holds the sequencer in
// that step while the output register is occupied. No clearing pass follows reset.
`default_nettype none
`include "infix_expression_evaluator_macros.svh"
module infix_expression_evaluator #(
	parameter int STACK_DEPTH = ieval_pkg::STACK_DEPTH_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	ieval_item_if.sink     item,
	ieval_result_if.source result
);
	import ieval_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t  state_q, state_n;
	mode_t   mode_q, mode_n;
	logic [CW-1:0] opnd_cnt_q, opnd_cnt_n;
	logic [CW-1:0] optr_cnt_q, optr_cnt_n;
	logic    in_num_q, in_num_n;
	status_t err_q, err_n;
	op_t     pend_q, pend_n;
	op_t     red_op_q, red_op_n;
	logic [31:0] b_q, b_n;

	// Latched input beat
	logic [7:0]  sym_q;
	logic [31:0] var_q;
	logic        last_q;

	// Output register
	logic        out_valid_q;
	logic [31:0] out_value_q;
	status_t     out_status_q;
	logic        load_out;

	// Stack RAM ports
	logic          opnd_we, optr_we;
	logic [AW-1:0] opnd_waddr, opnd_raddr, optr_waddr, optr_raddr;
	logic [31:0]   opnd_wdata, opnd_rdata;
	logic [2:0]    optr_wdata, optr_rdata;

	logic [CW-1:0] opnd_m1, opnd_m2, optr_m1;
	logic [31:0]   digit, dig_ext;
	op_t           top_op;
	logic          opnd_full, optr_full, is_digit, is_letter;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	assign opnd_m1   = opnd_cnt_q - CW'(1);
	assign opnd_m2   = opnd_cnt_q - CW'(2);
	assign optr_m1   = optr_cnt_q - CW'(1);
	assign opnd_full = opnd_cnt_q >= CW'(STACK_DEPTH);
	assign optr_full = optr_cnt_q >= CW'(STACK_DEPTH);
	assign digit     = {28'd0, 4'(sym_q - CH_0)};
	assign dig_ext   = (opnd_rdata << 3) + (opnd_rdata << 1) + digit;
	assign top_op    = op_t'(optr_rdata);
	assign is_digit  = sym_q >= CH_0 && sym_q <= CH_9;
	assign is_letter = (sym_q >= CH_LA && sym_q <= CH_LZ) ||
		(sym_q >= CH_UA && sym_q <= CH_UZ);

	// Read addresses: the top entry when peeking, the one below for operand a
	always_comb begin
		unique case (state_q)
			ST_LOOP_TOP, ST_DIG_RD: opnd_raddr = opnd_m1[AW-1:0];
			ST_RED_B:               opnd_raddr = opnd_m2[AW-1:0];
			default:                opnd_raddr = '0;
		endcase
	end
	assign optr_raddr = optr_m1[AW-1:0];

	always_comb begin
		state_n    = state_q;
		mode_n     = mode_q;
		opnd_cnt_n = opnd_cnt_q;
		optr_cnt_n = optr_cnt_q;
		in_num_n   = in_num_q;
		err_n      = err_q;
		pend_n     = pend_q;
		red_op_n   = red_op_q;
		b_n        = b_q;
		opnd_we    = 1'b0;
		opnd_waddr = opnd_cnt_q[AW-1:0];
		opnd_wdata = var_q;
		optr_we    = 1'b0;
		optr_waddr = optr_cnt_q[AW-1:0];
		optr_wdata = pend_q;
		alu_req    = '0;
		load_out   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_n = ST_DECODE;
				end
			end

			ST_DECODE: begin
				// Default: this character is done; continue with the end
				// reduction when it closes the expression
				state_n = last_q ? ST_LOOP_CHK : ST_IDLE;
				mode_n  = MODE_END;
				if (err_q == STAT_OK) begin
					if (is_digit) begin
						if (in_num_q && opnd_cnt_q != '0) begin
							state_n = ST_DIG_RD;
						end else begin
							in_num_n = 1'b1;
							if (opnd_full) begin
								err_n = STAT_BAD;
							end else begin
								opnd_we    = 1'b1;
								opnd_wdata = digit;
								opnd_cnt_n = opnd_cnt_q + CW'(1);
							end
						end
					end else begin
						in_num_n = 1'b0;
						if (is_letter) begin
							if (opnd_full) begin
								err_n = STAT_BAD;
							end else begin
								opnd_we    = 1'b1;
								opnd_cnt_n = opnd_cnt_q + CW'(1);
							end
						end else begin
							case (sym_q) inside
								CH_LPAR: begin
									if (optr_full) begin
										err_n = STAT_BAD;
									end else begin
										optr_we    = 1'b1;
										optr_wdata = OP_LPAR;
										optr_cnt_n = optr_cnt_q + CW'(1);
									end
								end
								CH_RPAR: begin
									mode_n  = MODE_RPAR;
									state_n = ST_LOOP_CHK;
								end
								CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: begin
									case (sym_q)
										CH_PLUS:  pend_n = OP_ADD;
										CH_MINUS: pend_n = OP_SUB;
										CH_STAR:  pend_n = OP_MUL;
										CH_SLASH: pend_n = OP_DIV;
										default:  pend_n = OP_POW;
									endcase
									mode_n  = MODE_OP;
									state_n = ST_LOOP_CHK;
								end
								default: err_n = STAT_BAD;
							endcase
						end
					end
				end
			end

			ST_DIG_RD: state_n = ST_DIG_WR;

			ST_DIG_WR: begin
				// Extend the number on top of the operand stack
				opnd_we    = 1'b1;
				opnd_waddr = opnd_m1[AW-1:0];
				opnd_wdata = dig_ext;
				state_n    = last_q ? ST_LOOP_CHK : ST_IDLE;
				mode_n     = MODE_END;
			end

			ST_LOOP_CHK: begin
				if (err_q != STAT_OK || (optr_cnt_q == '0 && mode_q == MODE_END)) begin
					state_n = (mode_q == MODE_END) ? ST_FIN_RD :
						(last_q ? ST_LOOP_CHK : ST_IDLE);
					mode_n  = MODE_END;
				end else if (optr_cnt_q == '0) begin
					if (mode_q == MODE_RPAR) begin
						err_n = STAT_BAD;
					end else begin
						optr_we    = 1'b1;
						optr_cnt_n = optr_cnt_q + CW'(1);
					end
					state_n = last_q ? ST_LOOP_CHK : ST_IDLE;
					mode_n  = MODE_END;
				end else begin
					state_n = ST_LOOP_TOP;
				end
			end

			ST_LOOP_TOP: begin
				// Decide between a reduction and ending the loop
				if (mode_q == MODE_RPAR && top_op == OP_LPAR) begin
					optr_cnt_n = optr_m1;
					state_n    = last_q ? ST_LOOP_CHK : ST_IDLE;
					mode_n     = MODE_END;
				end else if (mode_q == MODE_END && top_op == OP_LPAR) begin
					err_n   = STAT_BAD;
					state_n = ST_FIN_RD;
				end else if (mode_q == MODE_OP &&
					(top_op == OP_LPAR || rank(top_op) < rank(pend_q))) begin
					if (optr_full) begin
						err_n = STAT_BAD;
					end else begin
						optr_we    = 1'b1;
						optr_cnt_n = optr_cnt_q + CW'(1);
					end
					state_n = last_q ? ST_LOOP_CHK : ST_IDLE;
					mode_n  = MODE_END;
				end else begin
					optr_cnt_n = optr_m1;
					red_op_n   = top_op;
					if (opnd_cnt_q < CW'(2)) begin
						err_n   = STAT_BAD;
						state_n = ST_LOOP_CHK;
					end else begin
						state_n = ST_RED_B;
					end
				end
			end

			ST_RED_B: begin
				b_n     = opnd_rdata;
				state_n = ST_RED_A;
			end

			ST_RED_A: begin
				alu_req.start = 1'b1;
				alu_req.op    = red_op_q;
				alu_req.a     = opnd_rdata;
				alu_req.b     = b_q;
				state_n       = ST_RED_WAIT;
			end

			ST_RED_WAIT: begin
				if (alu_rsp.done) begin
					opnd_we    = 1'b1;
					opnd_waddr = opnd_m2[AW-1:0];
					opnd_wdata = alu_rsp.result;
					opnd_cnt_n = opnd_m1;
					if (err_q == STAT_OK && alu_rsp.div_zero) begin
						err_n = STAT_DIV0;
					end
					if (err_n == STAT_OK && red_op_q > OP_POW) begin
						err_n = STAT_BAD;
					end
					state_n = ST_LOOP_CHK;
				end
			end

			ST_FIN_RD: begin
				if (err_q == STAT_OK && opnd_cnt_q != CW'(1)) begin
					err_n = STAT_BAD;
				end
				state_n = ST_FIN_OUT;
			end

			ST_FIN_OUT: begin
				// Hold until the output register is free, then clear the stacks
				if (!out_valid_q || result.ready) begin
					load_out   = 1'b1;
					opnd_cnt_n = '0;
					optr_cnt_n = '0;
					in_num_n   = 1'b0;
					err_n      = STAT_OK;
					state_n    = ST_IDLE;
				end
			end

			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_END;
			opnd_cnt_q  <= '0;
			optr_cnt_q  <= '0;
			in_num_q    <= 1'b0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			mode_q     <= mode_n;
			opnd_cnt_q <= opnd_cnt_n;
			optr_cnt_q <= optr_cnt_n;
			in_num_q   <= in_num_n;
			err_q      <= err_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q   <= pend_n;
		red_op_q <= red_op_n;
		b_q      <= b_n;
		if (item.valid && item.ready) begin
			sym_q  <= item.symbol;
			var_q  <= item.variable_value;
			last_q <= item.last_symbol;
		end
		if (load_out) begin
			out_value_q  <= (err_q == STAT_OK) ? opnd_rdata : '0;
			out_status_q <= err_q;
		end
	end

	assign item.ready    = state_q == ST_IDLE;
	assign result.valid  = out_valid_q;
	assign result.value  = out_value_q;
	assign result.status = out_status_q;

	ieval_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_opnd_ram (
		.clk   (clk),
		.we    (opnd_we),
		.waddr (opnd_waddr),
		.wdata (opnd_wdata),
		.raddr (opnd_raddr),
		.rdata (opnd_rdata)
	);

	ieval_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_optr_ram (
		.clk   (clk),
		.we    (optr_we),
		.waddr (optr_waddr),
		.wdata (optr_wdata),
		.raddr (optr_raddr),
		.rdata (optr_rdata)
	);

	ieval_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	`IEVAL_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN_OUT), "result beat without final step")
	`IEVAL_ASSERT(a_alu_then_wait, alu_req.start |=> state_q == ST_RED_WAIT, "unit started outside a reduction")
	`IEVAL_ASSERT(a_err_zero_value, out_valid_q && out_status_q != STAT_OK |-> out_value_q == '0, "error result carries a value")
	`IEVAL_ASSERT_NEVER(a_stack_bound, opnd_cnt_q > CW'(STACK_DEPTH) || optr_cnt_q > CW'(STACK_DEPTH), "stack count past depth")
endmodule
`default_nettype wire

FILE: verif/infix_expression_evaluator_tb.sv
// Self-checking testbench for the two-stack infix expression evaluator.
`default_nettype none
module infix_expression_evaluator_tb;
	import ieval_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = STACK_DEPTH_DEF;

	typedef struct {
		logic [7:0]  symbol;
		logic [31:0] var_value;
		logic        last;
	} char_t;

	typedef struct {
		logic [31:0] value;
		status_t     status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ieval_item_if   item_ch();
	ieval_result_if result_ch();

	infix_expression_evaluator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch.sink),
		.result(result_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: our own copy of both stacks.
	logic [31:0] num_stack[DEPTH];
	op_t         op_stack[DEPTH];
	int          num_cnt, op_cnt;
	bit          digit_run;
	status_t     err;

	char_t   pending_chars[$];
	answer_t expected_answers[$];
	int      mismatches = 0;
	int      answers_seen = 0;
	int      chars_sent = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_recv = 1'b0;

	function automatic int op_rank(op_t c);
		case (c) inside
			OP_POW:         return 3;
			OP_MUL, OP_DIV: return 2;
			OP_ADD, OP_SUB: return 1;
			default:        return 0;
		endcase
	endfunction

	function automatic void raise(status_t s);
		if (err == STAT_OK)
			err = s;
	endfunction

	function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		if (b == 0) begin
			raise(STAT_DIV0);
			return 0;
		end
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	function automatic logic [31:0] raise_to(logic [31:0] base, logic [31:0] e);
		logic [31:0] r;
		r = 1;
		if (e[31]) begin
			if (base == 32'd1) return 1;
			if (base == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
			if (base == 0) begin
				raise(STAT_DIV0);
				return 0;
			end
			return 0;
		end
		while (e != 0) begin
			if (e[0]) r = r * base;
			base = base * base;
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic void clear_state();
		num_cnt = 0;
		op_cnt = 0;
		digit_run = 1'b0;
		err = STAT_OK;
	endfunction

	function automatic void push_num(logic [31:0] v);
		if (num_cnt >= DEPTH) begin
			raise(STAT_BAD);
			return;
		end
		num_stack[num_cnt++] = v;
	endfunction

	function automatic void push_op(op_t c);
		if (op_cnt >= DEPTH) begin
			raise(STAT_BAD);
			return;
		end
		op_stack[op_cnt++] = c;
	endfunction

	// Pop one operator and its two operands, push the result back.
	function automatic void collapse();
		op_t c;
		logic [31:0] a, b, r;
		if (op_cnt == 0) begin
			raise(STAT_BAD);
			return;
		end
		c = op_stack[--op_cnt];
		if (num_cnt < 2) begin
			raise(STAT_BAD);
			return;
		end
		b = num_stack[--num_cnt];
		a = num_stack[--num_cnt];
		case (c)
			OP_ADD:  r = a + b;
			OP_SUB:  r = a - b;
			OP_MUL:  r = a * b;
			OP_DIV:  r = quotient(a, b);
			OP_POW:  r = raise_to(a, b);
			default: begin
				raise(STAT_BAD);
				r = 0;
			end
		endcase
		num_stack[num_cnt++] = r;
	endfunction

	function automatic void absorb(logic [7:0] ch, logic [31:0] v);
		op_t c;
		if (ch >= CH_0 && ch <= CH_9) begin
			if (digit_run && num_cnt > 0)
				num_stack[num_cnt-1] = num_stack[num_cnt-1] * 10 + 32'(ch - CH_0);
			else begin
				push_num(32'(ch - CH_0));
				digit_run = 1'b1;
			end
			return;
		end
		digit_run = 1'b0;
		if ((ch >= CH_LA && ch <= CH_LZ) || (ch >= CH_UA && ch <= CH_UZ)) begin
			push_num(v);
			return;
		end
		case (ch)
			CH_PLUS:  c = OP_ADD;
			CH_MINUS: c = OP_SUB;
			CH_STAR:  c = OP_MUL;
			CH_SLASH: c = OP_DIV;
			CH_CARET: c = OP_POW;
			CH_LPAR: begin
				push_op(OP_LPAR);
				return;
			end
			CH_RPAR: begin
				while (err == STAT_OK && op_cnt > 0 && op_stack[op_cnt-1] != OP_LPAR)
					collapse();
				if (err != STAT_OK) return;
				if (op_cnt == 0) begin
					raise(STAT_BAD);
					return;
				end
				op_cnt--;
				return;
			end
			default: begin
				raise(STAT_BAD);
				return;
			end
		endcase
		while (err == STAT_OK && op_cnt > 0 && op_stack[op_cnt-1] != OP_LPAR &&
				op_rank(op_stack[op_cnt-1]) >= op_rank(c))
			collapse();
		if (err == STAT_OK)
			push_op(c);
	endfunction

	// Advance the predictor by one accepted beat; queue an answer on the last one.
	function automatic void predict_char(char_t ch);
		answer_t ans;
		if (err == STAT_OK)
			absorb(ch.symbol, ch.var_value);
		if (!ch.last)
			return;
		while (err == STAT_OK && op_cnt > 0) begin
			if (op_stack[op_cnt-1] == OP_LPAR) raise(STAT_BAD);
			else collapse();
		end
		if (err == STAT_OK && num_cnt != 1)
			raise(STAT_BAD);
		ans.value = (err == STAT_OK) ? num_stack[0] : 32'd0;
		ans.status = err;
		expected_answers.push_back(ans);
		clear_state();
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h (answer %0d)", what, got, want,
			answers_seen);
		mismatches++;
	endtask

	// Driver: offer the head of the queue, drop it once the beat is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.symbol <= '0;
			item_ch.variable_value <= '0;
			item_ch.last_symbol <= 1'b0;
		end else begin
			automatic bit took = item_ch.valid && item_ch.ready;
			automatic char_t ch;
			if (took) begin
				predict_char(pending_chars.pop_front());
				chars_sent++;
			end
			if ((!item_ch.valid || took) && pending_chars.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				ch = pending_chars[0];
				item_ch.valid <= 1'b1;
				item_ch.symbol <= ch.symbol;
				item_ch.variable_value <= ch.var_value;
				item_ch.last_symbol <= ch.last;
			end else if (took)
				item_ch.valid <= 1'b0;
		end
	end

	// Monitor: compare each taken result beat with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_answers.size() == 0)
					report("unexpected result", result_ch.value, 32'd0);
				else begin
					automatic answer_t a = expected_answers.pop_front();
					if (result_ch.value !== a.value)
						report("value", result_ch.value, a.value);
					if (result_ch.status !== a.status)
						report("status", 32'(result_ch.status), 32'(a.status));
				end
				answers_seen++;
			end
			result_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus builders.
	function automatic void put(logic [7:0] s, logic [31:0] v = 0, bit last = 0);
		char_t ch;
		ch.symbol = s;
		ch.var_value = v;
		ch.last = last;
		pending_chars.push_back(ch);
	endfunction

	function automatic void put_text(string t, logic [31:0] v = 0);
		for (int i = 0; i < t.len(); i++)
			put(t[i], v, i == t.len() - 1);
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(4))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			3: return CH_SLASH;
			default: return CH_CARET;
		endcase
	endfunction

	function automatic logic [31:0] rand_var();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(2);
			default: return $urandom;
		endcase
	endfunction

	// Emit one operand: a short number, a letter, or a parenthesized group.
	function automatic void rand_term(int lvl, logic [31:0] v, ref int budget);
		int k;
		k = $urandom_range(9);
		if (k < 2 && lvl < 3 && budget > 6) begin
			put(CH_LPAR, v);
			budget--;
			rand_expr(lvl + 1, v, budget);
			put(CH_RPAR, v);
			budget--;
		end else if (k < 5) begin
			put($urandom_range(1) ? 8'(CH_LA + $urandom_range(25)) :
				8'(CH_UA + $urandom_range(25)), v);
			budget--;
		end else begin
			for (int i = $urandom_range(1, k == 9 ? 11 : 2); i > 0; i--) begin
				put(8'(CH_0 + $urandom_range(9)), v);
				budget--;
			end
		end
	endfunction

	function automatic void rand_expr(int lvl, logic [31:0] v, ref int budget);
		rand_term(lvl, v, budget);
		while (budget > 2 && $urandom_range(3) != 0) begin
			put(rand_op(), v);
			budget--;
			rand_term(lvl, v, budget);
		end
	endfunction

	// One random expression; the final beat carries last_symbol.
	function automatic void rand_expression();
		logic [31:0] v;
		int budget;
		v = rand_var();
		budget = $urandom_range(1, 14);
		if ($urandom_range(9) == 0) begin
			// noise or a broken sequence: arbitrary bytes
			for (int i = $urandom_range(0, 4); i > 0; i--)
				put(8'($urandom_range(255)), $urandom);
			put(8'($urandom_range(255)), $urandom, 1'b1);
			return;
		end
		rand_expr(0, v, budget);
		if ($urandom_range(19) == 0)
			put(rand_op(), v);
		pending_chars[$].last = 1'b1;
	endfunction

	task automatic drain();
		while (pending_chars.size() > 0 || item_ch.valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		clear_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: operators, precedence, parentheses, error cases.
		put_text("2+3*4");
		put_text("(2+3)*4");
		put_text("100-7-3");
		put_text("2^3^2");
		put_text("x^0", 32'h8000_0000);
		put_text("0^0");
		put_text("7/0");
		put_text("a/b", 32'h8000_0000);
		put_text("x^(0-3)", 32'hFFFF_FFFF);
		put_text("0^(0-1)");
		put_text("5^(0-2)");
		put_text("4294967296*3");
		put_text("-5");
		put_text("(1+2");
		put_text("1+2)");
		put_text("1 2");
		put_text("x y", 32'd5);
		put(CH_RPAR, 0, 1'b1);
		put_text("Zz*99/7", 32'h7FFF_FFFF);
		put_text("6/0+1");
		for (int i = 0; i < DEPTH + 1; i++)
			put(CH_LPAR);
		put(CH_0, 0, 1'b1);
		drain();

		// Long receiver hold while the sender keeps going.
		for (int i = 0; i < 12; i++) rand_expression();
		hold_recv = 1'b1;
		repeat (2000) @(posedge clk);
		hold_recv = 1'b0;
		drain();

		// Random phases with different idling mixes.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 29 : 0;
			recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 29 : 0;
			while (pending_chars.size() < 40) rand_expression();
			drain();
		end

		$display("covered %0d characters, %0d results, with directed error cases", chars_sent,
			answers_seen);
		$display("and random expressions under sender gaps and receiver stalls");
		if (mismatches == 0)
			$display("PASS infix_expression_evaluator");
		else
			$display("FAIL infix_expression_evaluator");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL infix_expression_evaluator");
		$finish;
	end
endmodule
`default_nettype wire
